// File: hw/rtl/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// wavhp_pkg
// Types and constants shared by the WAV header parser modules.
// ----------------------------------------------------------------------------
package wavhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] MIN_FILE = 32'd44;
  localparam logic [32:0] MIN_FMT  = 33'd16;
  localparam logic [31:0] BITS_OFS = 32'd14;
  localparam logic [9:0]  MS_PER_S = 10'd1000;

  // status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SMALL    = 4'd1;
  localparam logic [3:0] ST_NOT_RIFF = 4'd2;
  localparam logic [3:0] ST_BAD_CHK  = 4'd3;
  localparam logic [3:0] ST_FMT_SML  = 4'd4;
  localparam logic [3:0] ST_NO_FMT   = 4'd5;
  localparam logic [3:0] ST_NO_DATA  = 4'd6;
  localparam logic [3:0] ST_NOT_PCM  = 4'd7;
  localparam logic [3:0] ST_CHANNELS = 4'd8;
  localparam logic [3:0] ST_BITS     = 4'd9;
  localparam logic [3:0] ST_RATE     = 4'd10;
  localparam logic [3:0] ST_EMPTY    = 4'd11;
  localparam logic [3:0] ST_LIMIT    = 4'd12;

  // register indexes
  localparam logic [0:0] REG_FILE_LEN = 1'd0;
  localparam logic [0:0] REG_MAX_DATA = 1'd1;

  typedef enum logic [2:0] {
    PH_RIFF, PH_HDR, PH_FMT, PH_SKIP, PH_TAIL, PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_DIV1, SQ_MUL, SQ_DIV2, SQ_OUT
  } seq_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
    logic [31:0] data_start;
    logic [31:0] dur_msec;
  } out_beat_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [41:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [41:0] quotient;
  } div_rsp_t;

endpackage

// File: hw/rtl/wavhp_div.sv
// ----------------------------------------------------------------------------
// wavhp_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wavhp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  wavhp_pkg::div_req_t req,
  output wavhp_pkg::div_rsp_t rsp
);
  import wavhp_pkg::*;

  logic [41:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  // one shift-subtract step
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[41]} - {1'b0, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 6'd42;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[33]) begin
        rem_nxt = {rem_r[31:0], quo_r[41]};
        quo_nxt = {quo_r[40:0], 1'b0};
      end else begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[40:0], 1'b1};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  ap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("divider did not start");
  ap_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  ap_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == 6'd0 || $past(req.start)) else $error("count stray");

endmodule

// File: hw/rtl/wav_header_parser_core.sv
// ----------------------------------------------------------------------------
// wav_header_parser_core
// Byte-wise RIFF/WAVE header walker with a shared divider for duration.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_stall is low; the last byte of a good
//   file holds in_stall high through two 42-step divider passes plus the
//   multiply and handover steps, and longer while out_stall is high.
// Result: out_valid rises in SQ_OUT, reached via SQ_DIV1, SQ_MUL and SQ_DIV2 for a good file, directly for faults.
// Reset: synchronous, active low; parse state clears, file_length 0,
//   max_data_bytes all ones.
module wav_header_parser_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wavhp_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wavhp_pkg::out_beat_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import wavhp_pkg::*;

  logic [31:0] flen_r, maxd_r;
  logic [31:0] pos_r, pos_nxt;
  phase_t      ph_r, ph_nxt;
  logic [31:0] fs_r, fs_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [32:0] left_r, left_nxt;
  logic [15:0] fmtc_r, fmtc_nxt, ch_r, ch_nxt, bits_r, bits_nxt;
  logic [31:0] rate_r, rate_nxt, doff_r, doff_nxt, dsz_r, dsz_nxt;
  logic [1:0]  found_r, found_nxt;
  logic [3:0]  fault_r, fault_nxt;
  seq_t        sq_r, sq_nxt;
  out_beat_t   ob_r, ob_nxt;
  logic [41:0] prod_r, prod_nxt;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        acc, wr;
  logic [7:0]  b;
  logic [32:0] start, lenp;
  logic [3:0]  st;
  logic [16:0] frame;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MAX_DATA) ? maxd_r : flen_r;

  assign in_stall = (sq_r != SQ_IDLE);
  assign acc = in_valid && !in_stall;
  assign b = in_data.data_byte;

  wavhp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // byte walker and result sequencer
  always_comb begin
    pos_nxt = pos_r; ph_nxt = ph_r; fs_nxt = fs_r; tag_nxt = tag_r;
    clen_nxt = clen_r; left_nxt = left_r; fmtc_nxt = fmtc_r; ch_nxt = ch_r;
    bits_nxt = bits_r; rate_nxt = rate_r; doff_nxt = doff_r; dsz_nxt = dsz_r;
    found_nxt = found_r; fault_nxt = fault_r;
    sq_nxt = sq_r; ob_nxt = ob_r; prod_nxt = prod_r;
    dreq = '0; st = ST_OK; start = '0; lenp = '0; frame = '0;
    unique case (sq_r)
      SQ_IDLE: begin
        if (acc) begin
          unique case (ph_r)
            PH_RIFF: begin
              if (pos_r < 32'd4 || pos_r >= 32'd8)
                tag_nxt = tag_r | ({24'd0, b} << {pos_r[1:0], 3'd0});
              if (pos_r == 32'd3) begin
                if (tag_nxt != TAG_RIFF) begin
                  fault_nxt = ST_NOT_RIFF; ph_nxt = PH_HALT;
                end else tag_nxt = '0;
              end else if (pos_r == 32'd11) begin
                if (tag_nxt != TAG_WAVE) begin
                  fault_nxt = ST_NOT_RIFF; ph_nxt = PH_HALT;
                end else begin
                  ph_nxt = PH_HDR; fs_nxt = '0; tag_nxt = '0; clen_nxt = '0;
                  left_nxt = '0;
                end
              end
            end
            PH_HDR: begin
              if (fs_r == '0 && ({1'b0, pos_r} + 33'd8) > {1'b0, flen_r}) begin
                ph_nxt = PH_TAIL;
              end else begin
                if (fs_r < 32'd4)
                  tag_nxt = tag_r | ({24'd0, b} << {fs_r[1:0], 3'd0});
                else
                  clen_nxt = clen_r | ({24'd0, b} << {fs_r[1:0], 3'd0});
                fs_nxt = fs_r + 32'd1;
                if (fs_nxt == 32'd8) begin
                  start = {1'b0, pos_r} + 33'd1;
                  lenp  = {1'b0, clen_nxt};
                  if (start + lenp > {1'b0, flen_r}) begin
                    fault_nxt = ST_BAD_CHK; ph_nxt = PH_HALT;
                  end else begin
                    left_nxt = lenp + {32'd0, clen_nxt[0]};
                    fs_nxt = '0;
                    if (tag_nxt == TAG_FMT && lenp < MIN_FMT) begin
                      fault_nxt = ST_FMT_SML; ph_nxt = PH_HALT;
                    end else begin
                      if (tag_nxt == TAG_FMT) begin
                        fmtc_nxt = '0; ch_nxt = '0; rate_nxt = '0; bits_nxt = '0;
                        found_nxt[0] = 1'b1; ph_nxt = PH_FMT;
                      end else begin
                        if (tag_nxt == TAG_DATA) begin
                          doff_nxt = start[31:0]; dsz_nxt = clen_nxt;
                          found_nxt[1] = 1'b1;
                        end
                        ph_nxt = PH_SKIP;
                      end
                      if (left_nxt == '0) begin
                        ph_nxt = PH_HDR; tag_nxt = '0; clen_nxt = '0;
                      end
                    end
                  end
                end
              end
            end
            PH_FMT: begin
              if (fs_r < 32'd2)
                fmtc_nxt = fmtc_r | ({8'd0, b} << {fs_r[0], 3'd0});
              else if (fs_r < 32'd4)
                ch_nxt = ch_r | ({8'd0, b} << {fs_r[0], 3'd0});
              else if (fs_r < 32'd8)
                rate_nxt = rate_r | ({24'd0, b} << {fs_r[1:0], 3'd0});
              else if (fs_r == BITS_OFS || fs_r == BITS_OFS + 32'd1)
                bits_nxt = bits_r | ({8'd0, b} << {fs_r[0], 3'd0});
              fs_nxt = fs_r + 32'd1;
              left_nxt = left_r - 33'd1;
              if (left_nxt == '0) begin
                ph_nxt = PH_HDR; fs_nxt = '0; tag_nxt = '0; clen_nxt = '0;
              end
            end
            PH_SKIP: begin
              left_nxt = left_r - 33'd1;
              if (left_nxt == '0) begin
                ph_nxt = PH_HDR; fs_nxt = '0; tag_nxt = '0; clen_nxt = '0;
              end
            end
            default: ;
          endcase
          pos_nxt = pos_r + 32'd1;
          if (in_data.last_byte) begin
            // frame size from the channel count this file ended with
            frame = {ch_nxt, 1'b0};
            // status checks in priority order
            if (flen_r < MIN_FILE) st = ST_SMALL;
            else if (fault_nxt != ST_OK) st = fault_nxt;
            else if (ph_nxt == PH_RIFF) st = ST_NOT_RIFF;
            else if (!found_nxt[0]) st = ST_NO_FMT;
            else if (!found_nxt[1]) st = ST_NO_DATA;
            else if (fmtc_nxt != 16'd1) st = ST_NOT_PCM;
            else if (ch_nxt < 16'd1 || ch_nxt > 16'd2) st = ST_CHANNELS;
            else if (bits_nxt != 16'd16) st = ST_BITS;
            else if (rate_nxt == '0) st = ST_RATE;
            else if ({1'b0, dsz_nxt} < {16'd0, frame}) st = ST_EMPTY;
            else if (dsz_nxt > maxd_r) st = ST_LIMIT;
            ob_nxt = '0;
            ob_nxt.status = st;
            if (st == ST_OK) begin
              ob_nxt.rate_hz       = rate_nxt;
              ob_nxt.channel_count = ch_nxt;
              ob_nxt.sample_bits   = bits_nxt;
              ob_nxt.data_length   = dsz_nxt;
              ob_nxt.data_start    = doff_nxt;
              dreq.start    = 1'b1;
              dreq.dividend = {10'd0, dsz_nxt};
              dreq.divisor  = {16'd0, frame};
              sq_nxt = SQ_DIV1;
            end else begin
              sq_nxt = SQ_OUT;
            end
            // fresh file follows
            pos_nxt = '0; ph_nxt = PH_RIFF; fs_nxt = '0; tag_nxt = '0;
            clen_nxt = '0; left_nxt = '0; fmtc_nxt = '0; ch_nxt = '0;
            bits_nxt = '0; rate_nxt = '0; doff_nxt = '0; dsz_nxt = '0;
            found_nxt = '0; fault_nxt = ST_OK;
          end
        end
      end
      SQ_DIV1: begin
        if (drsp.done) begin
          prod_nxt = drsp.quotient * 42'(MS_PER_S);
          sq_nxt = SQ_MUL;
        end
      end
      SQ_MUL: begin
        dreq.start    = 1'b1;
        dreq.dividend = prod_r;
        dreq.divisor  = {1'b0, ob_r.rate_hz};
        sq_nxt = SQ_DIV2;
      end
      SQ_DIV2: begin
        if (drsp.done) begin
          ob_nxt.dur_msec = drsp.quotient[31:0];
          sq_nxt = SQ_OUT;
        end
      end
      SQ_OUT: begin
        if (!out_stall) sq_nxt = SQ_IDLE;
      end
      default: sq_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    prod_r <= prod_nxt;
    if (!rst_n) begin
      flen_r <= '0; maxd_r <= '1;
      pos_r <= '0; ph_r <= PH_RIFF; fs_r <= '0; tag_r <= '0; clen_r <= '0;
      left_r <= '0; fmtc_r <= '0; ch_r <= '0; bits_r <= '0; rate_r <= '0;
      doff_r <= '0; dsz_r <= '0; found_r <= '0; fault_r <= ST_OK;
      sq_r <= SQ_IDLE;
    end else begin
      if (wr && paddr[2] == REG_FILE_LEN && paddr[1:0] == 2'd0) flen_r <= pwdata;
      if (wr && paddr[2] == REG_MAX_DATA && paddr[1:0] == 2'd0) maxd_r <= pwdata;
      pos_r <= pos_nxt; ph_r <= ph_nxt; fs_r <= fs_nxt; tag_r <= tag_nxt;
      clen_r <= clen_nxt; left_r <= left_nxt; fmtc_r <= fmtc_nxt; ch_r <= ch_nxt;
      bits_r <= bits_nxt; rate_r <= rate_nxt; doff_r <= doff_nxt; dsz_r <= dsz_nxt;
      found_r <= found_nxt; fault_r <= fault_nxt;
      sq_r <= sq_nxt;
    end
  end

  assign out_valid = (sq_r == SQ_OUT);
  assign out_data  = ob_r;

  ap_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r != ST_OK |-> ph_r == PH_HALT) else $error("fault without halt");
  ap_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.dur_msec == '0)
    else $error("fault result carries data");
  ap_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    sq_r != SQ_IDLE |-> in_stall) else $error("byte taken while busy");

endmodule
